// ===== design/pai_pkg.sv =====
package pai_pkg;

    localparam logic [2:0] ACT_APPEND   = 3'd0;
    localparam logic [2:0] ACT_INSERT   = 3'd1;
    localparam logic [2:0] ACT_DEL_LAST = 3'd2;
    localparam logic [2:0] ACT_DEL_POS  = 3'd3;
    localparam logic [2:0] ACT_READ_ALL = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef struct packed {
        logic [2:0]         action;
        logic [5:0]         position;
        logic signed [31:0] item_value;
    } pai_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] result_value;
        logic [5:0]         count_after;
        logic               last;
    } pai_out_t;

    typedef struct packed {
        logic accept;
        logic load_single;
        logic rd_start;
        logic rd_load;
    } pai_cmd_t;

    typedef struct packed {
        logic start_read;
        logic rd_last;
    } pai_stat_t;

endpackage

// ===== design/positional_array_insert_delete.sv =====
// positional array with insert and delete
// input channel s_valid/s_ready/s_data carries one request transaction:
// append, insert at a 1-based position, delete last, delete at a position,
// or read out all. result channel m_valid/m_ready/m_data returns status,
// removed or read value, count after the action and a last marker.
// append, insert and deletes: one result, registered in the cycle after the
// input transaction; one request per cycle while results are taken.
// inserts and deletes at a position move all cells from that position up
// at once. read out: one result per stored element, one per cycle while
// results are taken, loaded in the read state; the next request is taken
// after the last is registered; empty array read out gives a single result.
// failed requests (full, empty, bad position) report a status and change
// nothing. when the receiver stalls the result register holds and new
// requests wait; a request is still taken in the cycle its result slot
// frees up. reset clears the element count and both channels; storage
// contents are not cleared and are only read below the count.
module positional_array_insert_delete #(
    parameter int CAPACITY = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  pai_pkg::pai_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output pai_pkg::pai_out_t m_data
);

    pai_pkg::pai_cmd_t  cmd;
    pai_pkg::pai_stat_t stat;

    pai_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    pai_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_data  (m_data)
    );

endmodule

// ===== design/pai_ctrl.sv =====
module pai_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  pai_pkg::pai_stat_t stat,
    output pai_pkg::pai_cmd_t  cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic state_reg, state_next;
    logic m_valid_reg, m_valid_next;
    logic slot_free;

    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE) && slot_free;
    assign m_valid   = m_valid_reg;

    always_comb begin
        state_next      = state_reg;
        cmd.accept      = 1'b0;
        cmd.load_single = 1'b0;
        cmd.rd_start    = 1'b0;
        cmd.rd_load     = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && slot_free) begin
                    cmd.accept = 1'b1;
                    if (stat.start_read) begin
                        cmd.rd_start = 1'b1;
                        state_next   = S_READ;
                    end else begin
                        cmd.load_single = 1'b1;
                    end
                end
            end
            S_READ: begin
                if (slot_free) begin
                    cmd.rd_load = 1'b1;
                    if (stat.rd_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_single || cmd.rd_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== design/pai_dp.sv =====
module pai_dp #(
    parameter int CAPACITY = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  pai_pkg::pai_in_t   s_data,
    input  pai_pkg::pai_cmd_t  cmd,
    output pai_pkg::pai_stat_t stat,
    output pai_pkg::pai_out_t  m_data
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int IW    = $clog2(CAPACITY);
    localparam int CMP_W = (CW > 6) ? CW : 6;

    logic signed [31:0] cell_reg  [CAPACITY];
    logic signed [31:0] cell_next [CAPACITY];
    logic [CW-1:0]      count_reg, count_next;
    logic [IW-1:0]      rd_idx_reg, rd_idx_next;
    pai_pkg::pai_out_t  out_reg, out_next;

    logic [CMP_W-1:0]   pos_w, cnt_w;
    logic               full, empty, pos_ok;
    logic [IW-1:0]      k_idx, last_idx, rd_addr;
    logic [CW-1:0]      k_cnt;
    logic signed [31:0] rd_val;
    logic               do_app, do_ins, do_dlast, do_dpos;
    logic [1:0]         single_status;

    assign pos_w    = CMP_W'(s_data.position);
    assign cnt_w    = CMP_W'(count_reg);
    assign full     = cnt_w >= CMP_W'(CAPACITY);
    assign empty    = (count_reg == '0);
    assign pos_ok   = (pos_w != '0) && (pos_w <= cnt_w);
    assign k_idx    = IW'(s_data.position - 6'd1);
    assign k_cnt    = CW'(k_idx);
    assign last_idx = IW'(count_reg - CW'(1));

    // decode of the single-result actions
    always_comb begin
        do_app        = 1'b0;
        do_ins        = 1'b0;
        do_dlast      = 1'b0;
        do_dpos       = 1'b0;
        single_status = pai_pkg::ST_OK;
        unique case (s_data.action)
            pai_pkg::ACT_APPEND: begin
                if (full) single_status = pai_pkg::ST_FULL;
                else      do_app = 1'b1;
            end
            pai_pkg::ACT_INSERT: begin
                if (full)         single_status = pai_pkg::ST_FULL;
                else if (!pos_ok) single_status = pai_pkg::ST_RANGE;
                else              do_ins = 1'b1;
            end
            pai_pkg::ACT_DEL_LAST: begin
                if (empty) single_status = pai_pkg::ST_EMPTY;
                else       do_dlast = 1'b1;
            end
            pai_pkg::ACT_DEL_POS: begin
                if (empty)        single_status = pai_pkg::ST_EMPTY;
                else if (!pos_ok) single_status = pai_pkg::ST_RANGE;
                else              do_dpos = 1'b1;
            end
            pai_pkg::ACT_READ_ALL: begin
                if (empty) single_status = pai_pkg::ST_EMPTY;
            end
            default: begin
                single_status = pai_pkg::ST_OK;
            end
        endcase
    end

    assign stat.start_read = (s_data.action == pai_pkg::ACT_READ_ALL) && !empty;
    assign stat.rd_last    = (CW'(rd_idx_reg) == count_reg - CW'(1));

    // one read port shared by deletes and read out
    always_comb begin
        if (cmd.rd_load)    rd_addr = rd_idx_reg;
        else if (do_dlast)  rd_addr = last_idx;
        else                rd_addr = k_idx;
    end
    assign rd_val = cell_reg[rd_addr];

    // all affected cells shift in the same cycle
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            cell_next[i] = cell_reg[i];
            if (cmd.accept && do_app && (CW'(i) == count_reg)) begin
                cell_next[i] = s_data.item_value;
            end
            if (cmd.accept && do_ins) begin
                if (CW'(i) == k_cnt) begin
                    cell_next[i] = s_data.item_value;
                end else if (i > 0 && CW'(i) > k_cnt && CW'(i) <= count_reg) begin
                    cell_next[i] = cell_reg[(i > 0) ? i - 1 : 0];
                end
            end
            if (cmd.accept && do_dpos && i < CAPACITY - 1) begin
                if (CW'(i) >= k_cnt && CW'(i + 1) < count_reg) begin
                    cell_next[i] = cell_reg[(i < CAPACITY - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.accept && (do_app || do_ins)) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.accept && (do_dlast || do_dpos)) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb begin
        rd_idx_next = rd_idx_reg;
        if (cmd.rd_start) begin
            rd_idx_next = '0;
        end else if (cmd.rd_load) begin
            rd_idx_next = rd_idx_reg + IW'(1);
        end
    end

    always_comb begin
        out_next = out_reg;
        if (cmd.load_single) begin
            out_next.status       = single_status;
            out_next.result_value = (do_dlast || do_dpos) ? rd_val : 32'sd0;
            out_next.count_after  = 6'(count_next);
            out_next.last         = 1'b1;
        end else if (cmd.rd_load) begin
            out_next.status       = pai_pkg::ST_OK;
            out_next.result_value = rd_val;
            out_next.count_after  = 6'(count_reg);
            out_next.last         = stat.rd_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            rd_idx_reg <= '0;
        end else begin
            count_reg  <= count_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < CAPACITY; i++) begin
            cell_reg[i] <= cell_next[i];
        end
        out_reg <= out_next;
    end

    assign m_data = out_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(count_reg) <= CMP_W'(CAPACITY))
        else $error("element count above capacity");

    a_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && (do_app || do_ins)) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("count did not grow after insert");

    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_load |-> (CW'(rd_idx_reg) < count_reg))
        else $error("read out index past count");

    a_single_or_read: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.load_single && cmd.rd_load))
        else $error("two output loads in one cycle");

endmodule
